// ===== sv/vls_pkg.sv =====
// Package for the vehicle longitudinal speed step block.
// Holds field widths, register codes, control-word types and the microcode ROM.
// No dependencies.
`timescale 1ns / 1ps

package vls_pkg;

  // Field widths
  localparam int PEDAL_W    = 9;
  localparam int WHEEL_W    = 3;
  localparam int STEP_W     = 16;
  localparam int SPEED_W    = 24;
  localparam int RATE_W     = 23;
  localparam int DRAG_W     = 24;
  localparam int IN_W       = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Datapath widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 48;
  localparam int WS_W    = STEP_W + WHEEL_W;
  localparam int M_W     = RATE_W + PEDAL_W;
  localparam int DELTA_W = 24;
  localparam int VX_W    = SPEED_W + 2;

  localparam logic [RATE_W-1:0] ROLLING_RESISTANCE_DEF = 23'd2560;

  localparam logic signed [VX_W-1:0] SPEED_MAX_X = 26'sd8388607;
  localparam logic signed [VX_W-1:0] SPEED_MIN_X = -26'sd8388608;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] R_DCS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] R_BRAKE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] R_ENGINE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] R_REVERSE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] R_DRAG      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] R_HANDBRAKE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] R_REVLIM    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] R_FWDLIM    = 3'd7;

  localparam logic [RATE_W-1:0] DCS_RST       = 23'd1280;
  localparam logic [RATE_W-1:0] BRAKE_RST     = 23'd153600;
  localparam logic [RATE_W-1:0] ENGINE_RST    = 23'd102400;
  localparam logic [RATE_W-1:0] REVERSE_RST   = 23'd51200;
  localparam logic [DRAG_W-1:0] DRAG_RST      = 24'd8389;
  localparam logic [RATE_W-1:0] HANDBRAKE_RST = 23'd204800;
  localparam logic [RATE_W-1:0] REVLIM_RST    = 23'd76800;
  localparam logic [RATE_W-1:0] FWDLIM_RST    = 23'd256000;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  // Multiplier operand selects
  typedef enum logic [3:0] {
    A_ST, A_BRAKE, A_ENGINE, A_REVERSE, A_HANDBRAKE, A_ROLL, A_M, A_VABS,
    A_DRAG, A_ACC_HI, A_ACC_LO
  } a_sel_t;

  typedef enum logic [3:0] {
    B_WH, B_THR, B_BRK, B_HB, B_WS, B_ST, B_VABS, B_ACC_HI, B_ACC_LO
  } b_sel_t;

  // Where the product lands
  typedef enum logic [1:0] {MD_NONE, MD_WS, MD_M, MD_PROD} mdst_t;

  typedef enum logic {SRC_PROD, SRC_ACC} src_sel_t;

  typedef enum logic [2:0] {SH_0, SH_16, SH_18, SH_24, SH_26} shift_t;

  // Speed operation: toward zero, saturating add, saturating subtract, limit clamp
  typedef enum logic [2:0] {VOP_NONE, VOP_TZ, VOP_ADD, VOP_SUB, VOP_CLAMP} vop_t;

  typedef enum logic [1:0] {AOP_NONE, AOP_LOAD, AOP_ADD} aop_t;

  typedef enum logic [2:0] {
    JMP_NEVER, JMP_ALWAYS, JMP_BOTH, JMP_FROM_REV, JMP_FROM_FWD, JMP_PEDAL
  } cond_t;

  localparam int PC_W = 5;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    mdst_t             mdst;
    src_sel_t          src;
    shift_t            sh;
    vop_t              vop;
    aop_t              aop;
    cond_t             cond;
    logic [PC_W-1:0]   target;
    logic              last;
  } ucode_t;

  // Step addresses
  localparam logic [PC_W-1:0] ST_WS      = 5'd0;
  localparam logic [PC_W-1:0] ST_REV     = 5'd1;
  localparam logic [PC_W-1:0] ST_FWD     = 5'd2;
  localparam logic [PC_W-1:0] ST_ENG     = 5'd3;
  localparam logic [PC_W-1:0] ST_ENG_P   = 5'd4;
  localparam logic [PC_W-1:0] ST_ENG_ADD = 5'd5;
  localparam logic [PC_W-1:0] ST_REV_P   = 5'd6;
  localparam logic [PC_W-1:0] ST_REV_SUB = 5'd7;
  localparam logic [PC_W-1:0] ST_BRK_P   = 5'd8;
  localparam logic [PC_W-1:0] ST_BRK_TZ  = 5'd9;
  localparam logic [PC_W-1:0] ST_BOTH_P  = 5'd10;
  localparam logic [PC_W-1:0] ST_BOTH_TZ = 5'd11;
  localparam logic [PC_W-1:0] ST_ROLL_P  = 5'd12;
  localparam logic [PC_W-1:0] ST_ROLL_TZ = 5'd13;
  localparam logic [PC_W-1:0] ST_SQ      = 5'd14;
  localparam logic [PC_W-1:0] ST_SQ_LD   = 5'd15;
  localparam logic [PC_W-1:0] ST_T_HI    = 5'd16;
  localparam logic [PC_W-1:0] ST_T_LO    = 5'd17;
  localparam logic [PC_W-1:0] ST_T_ADD   = 5'd18;
  localparam logic [PC_W-1:0] ST_D_HI    = 5'd19;
  localparam logic [PC_W-1:0] ST_D_LO    = 5'd20;
  localparam logic [PC_W-1:0] ST_D_ADD   = 5'd21;
  localparam logic [PC_W-1:0] ST_DRAG_TZ = 5'd22;
  localparam logic [PC_W-1:0] ST_HB_P    = 5'd23;
  localparam logic [PC_W-1:0] ST_HB_TZ   = 5'd24;
  localparam logic [PC_W-1:0] ST_CLAMP   = 5'd25;

  localparam ucode_t UCODE_NOP = '{A_ST, B_WH, MD_NONE, SRC_PROD, SH_0, VOP_NONE,
                                   AOP_NONE, JMP_NEVER, ST_WS, 1'b0};

  // Microcode ROM. A step may start a multiply and, in the same cycle, use the
  // product register written by the step before.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = UCODE_NOP;
    case (pc)
      ST_WS:      w = '{A_ST, B_WH, MD_WS, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_BOTH, ST_BOTH_P, 1'b0};
      ST_REV:     w = '{A_BRAKE, B_THR, MD_M, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_FROM_REV, ST_BRK_P, 1'b0};
      ST_FWD:     w = '{A_BRAKE, B_BRK, MD_M, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_FROM_FWD, ST_BRK_P, 1'b0};
      ST_ENG:     w = '{A_ENGINE, B_THR, MD_M, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_ENG_P:   w = '{A_M, B_WS, MD_PROD, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_ENG_ADD: w = '{A_REVERSE, B_BRK, MD_M, SRC_PROD, SH_26, VOP_ADD, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_REV_P:   w = '{A_M, B_WS, MD_PROD, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_REV_SUB: w = '{A_ST, B_WH, MD_NONE, SRC_PROD, SH_26, VOP_SUB, AOP_NONE,
                        JMP_ALWAYS, ST_ROLL_P, 1'b0};
      ST_BRK_P:   w = '{A_M, B_WS, MD_PROD, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_BRK_TZ:  w = '{A_ST, B_WH, MD_NONE, SRC_PROD, SH_26, VOP_TZ, AOP_NONE,
                        JMP_ALWAYS, ST_ROLL_P, 1'b0};
      ST_BOTH_P:  w = '{A_BRAKE, B_WS, MD_PROD, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_BOTH_TZ: w = '{A_ST, B_WH, MD_NONE, SRC_PROD, SH_18, VOP_TZ, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_ROLL_P:  w = '{A_ROLL, B_ST, MD_PROD, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_PEDAL, ST_SQ, 1'b0};
      ST_ROLL_TZ: w = '{A_ST, B_WH, MD_NONE, SRC_PROD, SH_16, VOP_TZ, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_SQ:      w = '{A_VABS, B_VABS, MD_PROD, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_SQ_LD:   w = '{A_ST, B_WH, MD_NONE, SRC_PROD, SH_0, VOP_NONE, AOP_LOAD,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_T_HI:    w = '{A_ACC_HI, B_ST, MD_PROD, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_T_LO:    w = '{A_ACC_LO, B_ST, MD_PROD, SRC_PROD, SH_0, VOP_NONE, AOP_LOAD,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_T_ADD:   w = '{A_ST, B_WH, MD_NONE, SRC_PROD, SH_24, VOP_NONE, AOP_ADD,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_D_HI:    w = '{A_DRAG, B_ACC_HI, MD_PROD, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_D_LO:    w = '{A_DRAG, B_ACC_LO, MD_PROD, SRC_PROD, SH_0, VOP_NONE, AOP_LOAD,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_D_ADD:   w = '{A_ST, B_WH, MD_NONE, SRC_PROD, SH_24, VOP_NONE, AOP_ADD,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_DRAG_TZ: w = '{A_HANDBRAKE, B_HB, MD_M, SRC_ACC, SH_0, VOP_TZ, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_HB_P:    w = '{A_M, B_WS, MD_PROD, SRC_PROD, SH_0, VOP_NONE, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_HB_TZ:   w = '{A_ST, B_WH, MD_NONE, SRC_PROD, SH_26, VOP_TZ, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b0};
      ST_CLAMP:   w = '{A_ST, B_WH, MD_NONE, SRC_PROD, SH_0, VOP_CLAMP, AOP_NONE,
                        JMP_NEVER, ST_WS, 1'b1};
      default:    w = UCODE_NOP;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/vehicle_longitudinal_speed_step.sv =====
// Top level of the vehicle longitudinal speed step: microcoded sequencer and datapath.
// Depends on vls_pkg for widths, register codes and the microcode ROM.
`timescale 1ns / 1ps

// One solver step per input transaction updates the stored signed forward speed
// (Q16.8) and returns it with a flag that tells whether the speed limit clamp
// acted. An item is taken while the sequencer is idle and then runs 16 to 22
// microcode steps (both pedals: 16; braking against the motion: 17 or 18; plain
// drive: 21, or 22 with no pedal pressed). The step count is set by the single
// shared 32x24 multiplier, which every product of the step passes through in
// turn, one per cycle. The result sits in an output register, so the next item
// may be accepted while it waits; the sequencer only holds on its last step if
// the previous result has still not been taken. Configuration registers are
// written through the cfg channel, which is always ready, and should be changed
// only while idle.
module vehicle_longitudinal_speed_step
  import vls_pkg::*;
#(
  parameter logic [RATE_W-1:0] ROLLING_RESISTANCE = ROLLING_RESISTANCE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // throttle_level[8:0], brake_level[17:9], handbrake_level[26:18],
  // supported_wheels[29:27], step_time[45:30], zero fill[47:46]
  input  logic [IN_W-1:0]       s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // forward_speed[23:0]
  output logic [SPEED_W-1:0]    m_axis_tdata,
  // speed_limited[0]
  output logic                  m_axis_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [RATE_W-1:0] dcs, brake_rate, engine_rate, reverse_rate;
  logic [RATE_W-1:0] handbrake_rate, rev_limit, fwd_limit;
  logic [DRAG_W-1:0] drag;

  // Sequencer
  seq_state_t      state;
  logic [PC_W-1:0] pc;
  ucode_t          uw;
  logic            run, stall, taken, step_en;

  // Item and datapath registers
  logic [PEDAL_W-1:0]       thr, brk, hb;
  logic [WHEEL_W-1:0]       wh;
  logic [STEP_W-1:0]        st;
  logic                     from_fwd, from_rev;
  logic signed [SPEED_W-1:0] speed;
  logic [WS_W-1:0]          ws;
  logic [M_W-1:0]           m;
  logic [PROD_W-1:0]        prod;
  logic [ACC_W-1:0]         acc;
  logic [SPEED_W-1:0]       out_speed;
  logic                     out_limited, out_valid;

  // Combinational datapath
  logic                      thr_nz, brk_nz;
  logic [SPEED_W-1:0]        vabs;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [PROD_W-1:0]         product, src_val, shifted;
  logic [DELTA_W-1:0]        dsat;
  logic signed [VX_W-1:0]    vx, dx, sum, dif, neg_rev, pos_fwd, v_res, dcs_x;
  logic                      lim_res;

  assign s_axis_tready = (state == SEQ_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_speed;
  assign m_axis_tuser  = out_limited;

  assign run     = (state == SEQ_RUN);
  assign uw      = ucode_rom(pc);
  assign stall   = run && uw.last && out_valid && !m_axis_tready;
  assign step_en = run && !stall;

  assign thr_nz = |thr;
  assign brk_nz = |brk;

  always_comb begin
    unique case (uw.cond)
      JMP_NEVER:    taken = 1'b0;
      JMP_ALWAYS:   taken = 1'b1;
      JMP_BOTH:     taken = thr_nz && brk_nz;
      JMP_FROM_REV: taken = from_rev;
      JMP_FROM_FWD: taken = from_fwd;
      JMP_PEDAL:    taken = thr_nz || brk_nz;
      default:      taken = 1'b0;
    endcase
  end

  // The magnitude of the most negative speed still fits the unsigned 24 bits.
  assign vabs = speed[SPEED_W-1] ? SPEED_W'(-speed) : SPEED_W'(speed);

  always_comb begin
    case (uw.a_sel)
      A_ST:        mul_a = MUL_A_W'(st);
      A_BRAKE:     mul_a = MUL_A_W'(brake_rate);
      A_ENGINE:    mul_a = MUL_A_W'(engine_rate);
      A_REVERSE:   mul_a = MUL_A_W'(reverse_rate);
      A_HANDBRAKE: mul_a = MUL_A_W'(handbrake_rate);
      A_ROLL:      mul_a = MUL_A_W'(ROLLING_RESISTANCE);
      A_M:         mul_a = MUL_A_W'(m);
      A_VABS:      mul_a = MUL_A_W'(vabs);
      A_DRAG:      mul_a = MUL_A_W'(drag);
      A_ACC_HI:    mul_a = MUL_A_W'(acc[ACC_W-1:DELTA_W]);
      A_ACC_LO:    mul_a = MUL_A_W'(acc[DELTA_W-1:0]);
      default:     mul_a = '0;
    endcase
    case (uw.b_sel)
      B_WH:     mul_b = MUL_B_W'(wh);
      B_THR:    mul_b = MUL_B_W'(thr);
      B_BRK:    mul_b = MUL_B_W'(brk);
      B_HB:     mul_b = MUL_B_W'(hb);
      B_WS:     mul_b = MUL_B_W'(ws);
      B_ST:     mul_b = MUL_B_W'(st);
      B_VABS:   mul_b = MUL_B_W'(vabs);
      B_ACC_HI: mul_b = MUL_B_W'(acc[ACC_W-1:DELTA_W]);
      B_ACC_LO: mul_b = MUL_B_W'(acc[DELTA_W-1:0]);
      default:  mul_b = '0;
    endcase
  end

  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Scale the product or accumulator back to Q16.8 and saturate the delta.
  always_comb begin
    src_val = (uw.src == SRC_ACC) ? PROD_W'(acc) : prod;
    case (uw.sh)
      SH_0:    shifted = src_val;
      SH_16:   shifted = src_val >> 16;
      SH_18:   shifted = src_val >> 18;
      SH_24:   shifted = src_val >> 24;
      SH_26:   shifted = src_val >> 26;
      default: shifted = src_val;
    endcase
    dsat = (|shifted[PROD_W-1:DELTA_W]) ? '1 : shifted[DELTA_W-1:0];
  end

  always_comb begin
    vx      = VX_W'(speed);
    dx      = $signed({2'b00, dsat});
    sum     = vx + dx;
    dif     = vx - dx;
    neg_rev = -$signed({3'b000, rev_limit});
    pos_fwd = $signed({3'b000, fwd_limit});
    dcs_x   = $signed({3'b000, dcs});
    lim_res = 1'b0;
    case (uw.vop)
      VOP_TZ: begin
        if (speed[SPEED_W-1]) begin
          v_res = (sum > 0) ? '0 : sum;
        end else begin
          v_res = (dif < 0) ? '0 : dif;
        end
      end
      VOP_ADD:   v_res = (sum > SPEED_MAX_X) ? SPEED_MAX_X : sum;
      VOP_SUB:   v_res = (dif < SPEED_MIN_X) ? SPEED_MIN_X : dif;
      VOP_CLAMP: begin
        if (vx < neg_rev) begin
          v_res   = neg_rev;
          lim_res = 1'b1;
        end else if (vx > pos_fwd) begin
          v_res   = pos_fwd;
          lim_res = 1'b1;
        end else begin
          v_res = vx;
        end
      end
      default:   v_res = vx;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= SEQ_IDLE;
      pc             <= ST_WS;
      speed          <= '0;
      out_valid      <= 1'b0;
      dcs            <= DCS_RST;
      brake_rate     <= BRAKE_RST;
      engine_rate    <= ENGINE_RST;
      reverse_rate   <= REVERSE_RST;
      drag           <= DRAG_RST;
      handbrake_rate <= HANDBRAKE_RST;
      rev_limit      <= REVLIM_RST;
      fwd_limit      <= FWDLIM_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          R_DCS:       dcs            <= cfg_data[RATE_W-1:0];
          R_BRAKE:     brake_rate     <= cfg_data[RATE_W-1:0];
          R_ENGINE:    engine_rate    <= cfg_data[RATE_W-1:0];
          R_REVERSE:   reverse_rate   <= cfg_data[RATE_W-1:0];
          R_DRAG:      drag           <= cfg_data[DRAG_W-1:0];
          R_HANDBRAKE: handbrake_rate <= cfg_data[RATE_W-1:0];
          R_REVLIM:    rev_limit      <= cfg_data[RATE_W-1:0];
          R_FWDLIM:    fwd_limit      <= cfg_data[RATE_W-1:0];
        endcase
      end
      // A finishing step refills the output register in the cycle the old result leaves.
      if (step_en && uw.last) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        SEQ_IDLE: begin
          if (s_axis_tvalid) begin
            state <= SEQ_RUN;
            pc    <= ST_WS;
          end
        end
        SEQ_RUN: begin
          if (!stall) begin
            if (uw.vop != VOP_NONE) begin
              speed <= v_res[SPEED_W-1:0];
            end
            pc <= taken ? uw.target : pc + 1'b1;
            if (uw.last) begin
              state <= SEQ_IDLE;
            end
          end
        end
        default: state <= SEQ_IDLE;
      endcase
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      thr      <= s_axis_tdata[8:0];
      brk      <= s_axis_tdata[17:9];
      hb       <= s_axis_tdata[26:18];
      wh       <= s_axis_tdata[29:27];
      st       <= s_axis_tdata[45:30];
      // Direction decisions use the speed left by the previous step.
      from_fwd <= (|s_axis_tdata[17:9]) && (vx > dcs_x);
      from_rev <= (|s_axis_tdata[8:0]) && (vx < -dcs_x);
    end
    if (step_en) begin
      unique case (uw.mdst)
        MD_NONE: ;
        MD_WS:   ws   <= product[WS_W-1:0];
        MD_M:    m    <= product[M_W-1:0];
        MD_PROD: prod <= product;
        default: ;
      endcase
      case (uw.aop)
        AOP_LOAD: acc <= shifted[ACC_W-1:0];
        AOP_ADD:  acc <= acc + shifted[ACC_W-1:0];
        default:  ;
      endcase
      if (uw.last) begin
        out_speed   <= v_res[SPEED_W-1:0];
        out_limited <= lim_res;
      end
    end
  end

  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (run && uw.last && !stall) |=> m_axis_tvalid)
    else $error("finished step did not raise the output valid");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    run |-> (pc <= ST_CLAMP))
    else $error("step counter ran past the end of the program");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stall |=> (run && $stable(pc) && $stable(speed)))
    else $error("sequencer moved while the output was blocked");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (run && pc == ST_WS))
    else $error("accepted transaction did not start at the first step");

endmodule

// ===== sim/vehicle_longitudinal_speed_step_tb.sv =====
// Self-checking testbench for vehicle_longitudinal_speed_step: directed and random solver steps.
// Each result is checked against a typed-in value or this file's predictor under several register settings.
// Depends on vls_pkg and the vehicle_longitudinal_speed_step RTL.
`timescale 1ns / 1ps

module vehicle_longitudinal_speed_step_tb;
  import vls_pkg::*;

  typedef struct packed {
    logic [PEDAL_W-1:0] throttle;
    logic [PEDAL_W-1:0] brake;
    logic [PEDAL_W-1:0] handbrake;
    logic [WHEEL_W-1:0] wheels;
    logic [STEP_W-1:0]  step;
  } step_in_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      limited;
  } speed_out_t;

  typedef struct packed {
    step_in_t   item;
    logic       typed;
    speed_out_t result;
  } step_row_t;

  typedef enum int {MV_DRIVE, MV_REVERSE, MV_BOTH, MV_COAST, MV_NOISE} maneuver_t;

  localparam int SIDE_SRC = 0;
  localparam int SIDE_SINK = 1;
  localparam int N_DIRECTED = 22;
  localparam int N_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 105;
  localparam longint unsigned ROLL_DECEL = ROLLING_RESISTANCE_DEF;

  // Only the first rows, taken from rest, have their result typed in.
  localparam step_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{'{9'd0,   9'd0,   9'd0,   3'd4, 16'd65535}, 1'b1, '{24'sd0, 1'b0}},
    '{'{9'd256, 9'd0,   9'd0,   3'd0, 16'd65535}, 1'b1, '{24'sd0, 1'b0}},
    '{'{9'd0,   9'd256, 9'd0,   3'd0, 16'd65535}, 1'b1, '{24'sd0, 1'b0}},
    '{'{9'd256, 9'd0,   9'd0,   3'd4, 16'd0},     1'b1, '{24'sd0, 1'b0}},
    '{'{9'd256, 9'd0,   9'd0,   3'd4, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd511, 9'd0,   9'd0,   3'd7, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd511, 9'd0,   9'd0,   3'd7, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd511, 9'd0,   9'd0,   3'd7, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd0,   9'd0,   9'd0,   3'd4, 16'd0},     1'b0, '{24'sd0, 1'b0}},
    '{'{9'd0,   9'd256, 9'd0,   3'd4, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd256, 9'd256, 9'd0,   3'd4, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd0,   9'd0,   9'd0,   3'd4, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd0,   9'd0,   9'd511, 3'd7, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd0,   9'd511, 9'd0,   3'd7, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd0,   9'd511, 9'd0,   3'd7, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd256, 9'd0,   9'd0,   3'd4, 16'd8000},  1'b0, '{24'sd0, 1'b0}},
    '{'{9'd0,   9'd100, 9'd0,   3'd4, 16'd1092},  1'b0, '{24'sd0, 1'b0}},
    '{'{9'd0,   9'd0,   9'd0,   3'd4, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd511, 9'd511, 9'd511, 3'd7, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd0,   9'd0,   9'd256, 3'd4, 16'd65535}, 1'b0, '{24'sd0, 1'b0}},
    '{'{9'd1,   9'd0,   9'd0,   3'd1, 16'd1},     1'b0, '{24'sd0, 1'b0}},
    '{'{9'd0,   9'd1,   9'd0,   3'd1, 16'd1},     1'b0, '{24'sd0, 1'b0}}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [SPEED_W-1:0]    m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: stored speed and the register file as the block should hold it.
  logic signed [SPEED_W-1:0] model_speed;
  longint unsigned           cfg_val [8];
  longint unsigned           rst_val [8];
  logic [CFG_DATA_W-1:0]     phase_cfg [8];

  speed_out_t speed_q [$];
  int         run_left [2];
  bit         run_quiet [2];
  int         mismatch_count = 0;
  int         results_seen = 0;
  int         clamps_seen = 0;
  int         steps_sent = 0;

  vehicle_longitudinal_speed_step u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("vehicle_longitudinal_speed_step test failed");
    $finish;
  end

  function automatic longint unsigned clip_delta(input longint unsigned d);
    return (d > 64'd16777215) ? 64'd16777215 : d;
  endfunction

  // rate (Q16.8 per second) x wheels/4 x pedal (Q1.8) x step (Q0.16) gives a Q16.8 delta.
  function automatic longint unsigned pedal_term(input longint unsigned rate,
                                                 input longint unsigned wh,
                                                 input longint unsigned pedal,
                                                 input longint unsigned st);
    return clip_delta((rate * wh * pedal * st) >> 26);
  endfunction

  function automatic longint sat_v(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint to_zero(input longint v, input longint unsigned d);
    longint dd;
    dd = d;
    if (v < 0) return (v + dd > 0) ? 0 : v + dd;
    return (v - dd < 0) ? 0 : v - dd;
  endfunction

  function automatic void integrate_speed(input step_in_t s, output speed_out_t r);
    longint v, dcs, lim;
    longint unsigned thr, brk, hb, wh, st, sq, t, d;
    bit from_fwd, from_rev, limited;
    thr = s.throttle;
    brk = s.brake;
    hb = s.handbrake;
    wh = s.wheels;
    st = s.step;
    v = model_speed;
    dcs = cfg_val[R_DCS];
    from_fwd = (brk != 0) && (v > dcs);
    from_rev = (thr != 0) && (v < -dcs);
    limited = 1'b0;

    if (thr != 0 && brk != 0) begin
      d = clip_delta((cfg_val[R_BRAKE] * wh * st) >> 18);
      v = to_zero(v, d);
    end else if (from_rev) begin
      v = to_zero(v, pedal_term(cfg_val[R_BRAKE], wh, thr, st));
    end else if (from_fwd) begin
      v = to_zero(v, pedal_term(cfg_val[R_BRAKE], wh, brk, st));
    end else begin
      v = sat_v(v + $signed(pedal_term(cfg_val[R_ENGINE], wh, thr, st)));
      v = sat_v(v - $signed(pedal_term(cfg_val[R_REVERSE], wh, brk, st)));
    end

    if (thr == 0 && brk == 0) v = to_zero(v, clip_delta((ROLL_DECEL * st) >> 16));

    // Quadratic drag, kept in two scaling stages so nothing overflows 64 bits.
    sq = (v < 0) ? -v : v;
    sq = sq * sq;
    t = (sq * st) >> 24;
    v = to_zero(v, clip_delta((t * cfg_val[R_DRAG]) >> 24));

    v = to_zero(v, pedal_term(cfg_val[R_HANDBRAKE], wh, hb, st));

    lim = cfg_val[R_REVLIM];
    if (v < -lim) begin
      v = -lim;
      limited = 1'b1;
    end else begin
      lim = cfg_val[R_FWDLIM];
      if (v > lim) begin
        v = lim;
        limited = 1'b1;
      end
    end

    model_speed = 24'(v);
    r.speed = 24'(v);
    r.limited = limited;
  endfunction

  task automatic reset_model();
    rst_val[R_DCS] = DCS_RST;
    rst_val[R_BRAKE] = BRAKE_RST;
    rst_val[R_ENGINE] = ENGINE_RST;
    rst_val[R_REVERSE] = REVERSE_RST;
    rst_val[R_DRAG] = DRAG_RST;
    rst_val[R_HANDBRAKE] = HANDBRAKE_RST;
    rst_val[R_REVLIM] = REVLIM_RST;
    rst_val[R_FWDLIM] = FWDLIM_RST;
    cfg_val = rst_val;
    model_speed = '0;
  endtask

  // Gaps come in runs: some runs never idle, the others draw a random idle gap before each transaction.
  function automatic int draw_gap(input int side);
    if (run_left[side] == 0) begin
      run_left[side] = $urandom_range(4, 40);
      run_quiet[side] = ($urandom_range(0, 2) == 0);
    end
    run_left[side]--;
    return run_quiet[side] ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [PEDAL_W-1:0] pick_pedal();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 9'($urandom_range(257, 511));
    if (r < 3) return 9'd256;
    return 9'($urandom_range(1, 256));
  endfunction

  function automatic step_in_t random_step(input maneuver_t mv);
    step_in_t s;
    s.throttle = '0;
    s.brake = '0;
    s.wheels = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) :
                                             3'($urandom_range(2, 4));
    s.step = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(200, 20000));
    s.handbrake = ($urandom_range(0, 5) == 0) ? pick_pedal() : 9'd0;
    case (mv)
      MV_DRIVE:   s.throttle = pick_pedal();
      MV_REVERSE: s.brake = pick_pedal();
      MV_BOTH: begin
        s.throttle = pick_pedal();
        s.brake = pick_pedal();
      end
      MV_COAST:   ;
      default: begin
        s.throttle = 9'($urandom);
        s.brake = 9'($urandom);
        s.handbrake = 9'($urandom);
        s.wheels = 3'($urandom);
        s.step = 16'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic send_step(input step_in_t s, input logic typed, input speed_out_t typed_r);
    int gap;
    speed_out_t r;
    gap = draw_gap(SIDE_SRC);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {2'b00, s.step, s.wheels, s.handbrake, s.brake, s.throttle};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    integrate_speed(s, r);
    speed_q.push_back(typed ? typed_r : r);
    steps_sent++;
    @(negedge clk);
  endtask

  // Registers go in back to back; valid drops only after the last one.
  task automatic load_config();
    for (int i = 0; i < 8; i++) begin
      cfg_index <= 3'(i);
      cfg_data <= phase_cfg[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      cfg_val[i] = (3'(i) == R_DRAG) ? {40'd0, phase_cfg[i]} : {41'd0, phase_cfg[i][22:0]};
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (speed_q.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  // Result side: stalls drawn per transaction.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = draw_gap(SIDE_SINK);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    speed_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (speed_q.size() == 0) begin
        $display("%0t: unexpected result speed %0d limited %0b", $time,
                 $signed(m_axis_tdata), m_axis_tuser);
        mismatch_count++;
      end else begin
        want = speed_q.pop_front();
        results_seen++;
        if (m_axis_tuser === 1'b1) clamps_seen++;
        if (m_axis_tdata !== want.speed) begin
          $display("%0t: forward_speed expected %0d got %0d", $time,
                   $signed(want.speed), $signed(m_axis_tdata));
          mismatch_count++;
        end
        if (m_axis_tuser !== want.limited) begin
          $display("%0t: speed_limited expected %0b got %0b", $time,
                   want.limited, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int run_len;
    maneuver_t mv;
    int r;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    run_left = '{0, 0};
    run_quiet = '{0, 0};
    reset_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED_ROWS[i])
      send_step(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
    settle();

    // Setting 0 keeps the reset values; later ones cover both extremes, random and tight limits.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      if (phase > 0) begin
        for (int i = 0; i < 8; i++) begin
          case (phase)
            1: phase_cfg[i] = 24'hFFFFFF;
            2: phase_cfg[i] = 24'h000000;
            3: phase_cfg[i] = 24'($urandom);
            4, 5: phase_cfg[i] = 24'($urandom_range(32'(rst_val[i] / 4), 32'(rst_val[i] * 2)));
            default: phase_cfg[i] = 24'(rst_val[i]);
          endcase
        end
        if (phase == 5) begin
          phase_cfg[R_DCS] = 24'($urandom_range(0, 8388607));
          phase_cfg[R_REVLIM] = 24'($urandom_range(0, 3000));
          phase_cfg[R_FWDLIM] = 24'($urandom_range(0, 3000));
        end
        load_config();
      end
      run_len = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (run_len == 0) begin
          r = $urandom_range(0, 9);
          mv = (r < 4) ? MV_DRIVE : (r < 7) ? MV_REVERSE : (r == 7) ? MV_BOTH :
               (r == 8) ? MV_COAST : MV_NOISE;
          run_len = $urandom_range(3, 25);
        end
        run_len--;
        send_step(random_step(mv), 1'b0, '0);
      end
      settle();
    end

    $display("Ran %0d solver steps over %0d register settings.", steps_sent, N_PHASES);
    $display("Checked %0d results, %0d of them clamped by a speed limit.",
             results_seen, clamps_seen);
    if (mismatch_count == 0 && speed_q.size() == 0) begin
      $display("vehicle_longitudinal_speed_step test passed");
    end else begin
      $display("vehicle_longitudinal_speed_step test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/vls_pkg.sv
sv/vehicle_longitudinal_speed_step.sv
sim/vehicle_longitudinal_speed_step_tb.sv
